// ===== hdl/grpe_pkg.sv =====
// Shared constants, types and a helper function for the glyph row pixel expander.
`timescale 1ns / 1ps
`default_nettype none

package grpe_pkg;

  localparam int GLYPH_ROWS_DEF = 16;
  localparam int MAX_SCALE_DEF  = 4;

  localparam int SCALE_W      = 3;
  localparam int COLOR_W      = 16;
  localparam int PITCH_W      = 11;
  localparam int BYTE_W       = 8;
  localparam int ROW_BITS_W   = 16;
  localparam int PIX_PER_WORD = 4;
  localparam int PIX_W        = 16;
  localparam int WORD_W       = 64;
  localparam int OFFSET_W     = 16;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 16;
  localparam int PIX_IDX_W    = 6;   // pixel index within a line, up to 63
  localparam int SRC_W        = 4;   // source bit index within a glyph row

  localparam logic [SCALE_W-1:0] SCALE_RST = 3'd1;
  localparam logic [COLOR_W-1:0] COLOR_RST = 16'hFFFF;
  localparam logic [PITCH_W-1:0] PITCH_RST = 11'd160;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE = 4'd0,
    CFG_COLOR = 4'd1,
    CFG_PITCH = 4'd2,
    CFG_WIDE  = 4'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [COLOR_W-1:0] pixel_color;
    logic [PITCH_W-1:0] pitch_words;
    logic               wide_glyph;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0]   pixel_word;
    logic [OFFSET_W-1:0] word_offset;
    logic                row_last;
    logic                glyph_last;
  } word_t;

  // Source glyph bit for an output pixel: pix / scale, scale 1..4.
  // Divide by three as multiply by 171 and shift by 9 (exact below 128).
  function automatic logic [SRC_W-1:0] src_of(input logic [PIX_IDX_W-1:0] pix,
                                               input logic [SCALE_W-1:0]   sc);
    logic [13:0] prod;
    logic [SRC_W-1:0] res;
    prod = 14'(pix) * 14'd171;
    case (sc)
      3'd2:    res = pix[4:1];
      3'd3:    res = prod[12:9];
      3'd4:    res = pix[5:2];
      default: res = pix[3:0];
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/grpe_cfg.sv =====
// Configuration register file: scale, color, pitch and glyph width.
`timescale 1ns / 1ps
`default_nettype none

module grpe_cfg (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire  [grpe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [grpe_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output grpe_pkg::cfg_t                  cfg_o
);
  import grpe_pkg::*;

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SCALE: cfg_d.scale       = cfg_wdata_i[SCALE_W-1:0];
        CFG_COLOR: cfg_d.pixel_color = cfg_wdata_i[COLOR_W-1:0];
        CFG_PITCH: cfg_d.pitch_words = cfg_wdata_i[PITCH_W-1:0];
        CFG_WIDE:  cfg_d.wide_glyph  = cfg_wdata_i[0];
        default:   cfg_d = cfg_q;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale       <= SCALE_RST;
      cfg_q.pixel_color <= COLOR_RST;
      cfg_q.pitch_words <= PITCH_RST;
      cfg_q.wide_glyph  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/grpe_word_gen.sv =====
// Row register, line/word counters and per-word pixel and offset logic.
`timescale 1ns / 1ps
`default_nettype none

module grpe_word_gen #(
  parameter int GLYPH_ROWS = grpe_pkg::GLYPH_ROWS_DEF,
  parameter int MAX_SCALE  = grpe_pkg::MAX_SCALE_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire  [grpe_pkg::BYTE_W-1:0] left_bits_i,
  input  wire  [grpe_pkg::BYTE_W-1:0] right_bits_i,
  input  grpe_pkg::cfg_t              cfg_i,
  output logic                        word_valid_o,
  input  wire                         word_ready_i,
  output grpe_pkg::word_t             word_o
);
  import grpe_pkg::*;

  localparam int RowW  = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int LineW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int WordW = $clog2(PIX_PER_WORD * MAX_SCALE);
  localparam int WplW  = $clog2(PIX_PER_WORD * MAX_SCALE + 1);
  localparam int DstW  = (MAX_SCALE * GLYPH_ROWS > 1) ? $clog2(MAX_SCALE * GLYPH_ROWS) : 1;
  localparam int PrdW  = DstW + PITCH_W;

  localparam logic [RowW-1:0]    LastRow  = RowW'(GLYPH_ROWS - 1);
  localparam logic [SCALE_W-1:0] MaxScale = SCALE_W'(MAX_SCALE);

  // control state
  logic              busy_d, busy_q;
  logic [RowW-1:0]   row_d, row_q;
  logic [LineW-1:0]  line_d, line_q;
  logic [WordW-1:0]  w_d, w_q;
  logic [DstW-1:0]   dst_d, dst_q;

  // per-row snapshot
  logic [ROW_BITS_W-1:0] bits_q;
  logic [SCALE_W-1:0]    sc_q;
  logic                  wide_q;
  logic                  final_q;
  logic [COLOR_W-1:0]    color_q;
  logic [PITCH_W-1:0]    pitch_q;

  logic [SCALE_W-1:0]      sc_clamp;
  logic [SCALE_W+RowW-1:0] start_prod;
  logic [WplW-1:0]         wpl;
  logic                    w_last, line_last, item_last;
  logic                    advance, take;
  logic [PrdW-1:0]         off_prod;
  logic [PrdW:0]           off_sum;
  logic [WORD_W-1:0]       pix_word;

  always_comb begin
    if (cfg_i.scale == '0) begin
      sc_clamp = SCALE_W'(1);
    end else if (cfg_i.scale > MaxScale) begin
      sc_clamp = MaxScale;
    end else begin
      sc_clamp = cfg_i.scale;
    end
  end

  assign start_prod = (SCALE_W+RowW)'(sc_clamp) * (SCALE_W+RowW)'(row_q);

  assign wpl       = wide_q ? (WplW'(sc_q) << 2) : (WplW'(sc_q) << 1);
  assign w_last    = (WplW'(w_q) == (wpl - WplW'(1)));
  assign line_last = (SCALE_W'(line_q) == (sc_q - SCALE_W'(1)));
  assign item_last = w_last & line_last;

  assign advance    = busy_q & word_ready_i;
  assign in_stall_o = busy_q & ~(advance & item_last);
  assign take       = in_valid_i & ~in_stall_o;

  always_comb begin
    busy_d = busy_q;
    row_d  = row_q;
    line_d = line_q;
    w_d    = w_q;
    dst_d  = dst_q;
    if (advance) begin
      if (item_last) begin
        busy_d = 1'b0;
      end else if (w_last) begin
        w_d    = '0;
        line_d = line_q + LineW'(1);
        dst_d  = dst_q + DstW'(1);
      end else begin
        w_d = w_q + WordW'(1);
      end
    end
    if (take) begin
      busy_d = 1'b1;
      line_d = '0;
      w_d    = '0;
      dst_d  = DstW'(start_prod);
      row_d  = (row_q >= LastRow) ? '0 : row_q + RowW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= '0;
      line_q <= '0;
      w_q    <= '0;
      dst_q  <= '0;
    end else begin
      busy_q <= busy_d;
      row_q  <= row_d;
      line_q <= line_d;
      w_q    <= w_d;
      dst_q  <= dst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      bits_q  <= {left_bits_i, (cfg_i.wide_glyph ? right_bits_i : BYTE_W'(0))};
      sc_q    <= sc_clamp;
      wide_q  <= cfg_i.wide_glyph;
      final_q <= (row_q >= LastRow);
      color_q <= cfg_i.pixel_color;
      pitch_q <= cfg_i.pitch_words;
    end
  end

  // four pixels of the current word
  for (genvar p = 0; p < PIX_PER_WORD; p++) begin : g_pix
    logic [WordW+1:0] pix;
    logic [SRC_W-1:0] src;
    assign pix = {w_q, 2'(p)};
    assign src = src_of(PIX_IDX_W'(pix), sc_q);
    assign pix_word[p*PIX_W +: PIX_W] = bits_q[SRC_W'(ROW_BITS_W - 1) - src] ? color_q : '0;
  end

  assign off_prod = PrdW'(dst_q) * PrdW'(pitch_q);
  assign off_sum  = (PrdW+1)'(off_prod) + (PrdW+1)'(w_q);

  assign word_valid_o       = busy_q;
  assign word_o.pixel_word  = pix_word;
  assign word_o.word_offset = OFFSET_W'(off_sum);
  assign word_o.row_last    = item_last;
  assign word_o.glyph_last  = item_last & final_q;

endmodule

`default_nettype wire

// ===== hdl/grpe_out_stage.sv =====
// Output register stage with valid/stall handshake.
`timescale 1ns / 1ps
`default_nettype none

module grpe_out_stage (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             word_valid_i,
  output logic            word_ready_o,
  input  grpe_pkg::word_t word_i,
  output logic            out_valid_o,
  input  wire             out_stall_i,
  output grpe_pkg::word_t out_o
);
  import grpe_pkg::*;

  logic  valid_d, valid_q;
  word_t data_q;
  logic  take;

  assign word_ready_o = ~valid_q | ~out_stall_i;
  assign take         = word_valid_i & word_ready_o;
  assign valid_d      = take | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

`default_nettype wire

// ===== hdl/glyph_row_pixel_expander.sv =====
// Top level of the glyph row pixel expander (OSD character generator).
// A row request's first word passes the generator register, then the result register,
//   on its way to the outputs.
// Throughput: one 64-bit word per cycle while the output is not stalled; a row yields
//   2*scale*scale (narrow) or 4*scale*scale (wide) words, 2..64, from the single word generator stage.
// The next row request is taken while the last word of the current one goes out.
// Reset: async active low; registers to defaults, glyph row counter to zero.
`timescale 1ns / 1ps
`default_nettype none

module glyph_row_pixel_expander #(
  parameter int GLYPH_ROWS = grpe_pkg::GLYPH_ROWS_DEF,
  parameter int MAX_SCALE  = grpe_pkg::MAX_SCALE_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // configuration writes
  input  wire                             cfg_we_i,
  input  wire  [grpe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [grpe_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // glyph row requests
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire  [grpe_pkg::BYTE_W-1:0]     left_bits_i,
  input  wire  [grpe_pkg::BYTE_W-1:0]     right_bits_i,
  // pixel word requests
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic [grpe_pkg::WORD_W-1:0]     pixel_word_o,
  output logic [grpe_pkg::OFFSET_W-1:0]   word_offset_o,
  output logic                            row_last_o,
  output logic                            glyph_last_o
);
  import grpe_pkg::*;

  cfg_t  cfg;
  word_t gen_word;
  word_t out_word;
  logic  gen_valid;
  logic  gen_ready;

  // Register file. Writes are expected only while idle; a row snapshots what
  // it needs when it is accepted.
  grpe_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Holds the current row, walks lines and words, forms pixels and offset.
  grpe_word_gen #(
    .GLYPH_ROWS (GLYPH_ROWS),
    .MAX_SCALE  (MAX_SCALE)
  ) u_word_gen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .left_bits_i  (left_bits_i),
    .right_bits_i (right_bits_i),
    .cfg_i        (cfg),
    .word_valid_o (gen_valid),
    .word_ready_i (gen_ready),
    .word_o       (gen_word)
  );

  // Result register: holds the word under downstream stall; the stall reaches the generator through its ready.
  grpe_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (gen_valid),
    .word_ready_o (gen_ready),
    .word_i       (gen_word),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (out_word)
  );

  assign pixel_word_o  = out_word.pixel_word;
  assign word_offset_o = out_word.word_offset;
  assign row_last_o    = out_word.row_last;
  assign glyph_last_o  = out_word.glyph_last;

endmodule

`default_nettype wire

// ===== hdl/grpe_checker.sv =====
// Port-level assertions for the glyph row pixel expander, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module grpe_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             in_valid_i,
  input wire                             in_stall_o,
  input wire                             out_valid_o,
  input wire                             out_stall_i,
  input wire [grpe_pkg::WORD_W-1:0]      pixel_word_o,
  input wire [grpe_pkg::OFFSET_W-1:0]    word_offset_o,
  input wire                             row_last_o,
  input wire                             glyph_last_o
);

  // output request held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output request dropped under stall");

  // stalled payload stays put
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pixel_word_o) && $stable(word_offset_o)
      && $stable(row_last_o) && $stable(glyph_last_o))
    else $error("output payload changed under stall");

  // end of glyph is always also end of row
  a_glyph_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && glyph_last_o |-> row_last_o)
    else $error("glyph_last without row_last");

  // nothing offered while in reset
  a_rst_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("activity during reset");

endmodule

bind glyph_row_pixel_expander grpe_checker u_grpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .pixel_word_o  (pixel_word_o),
  .word_offset_o (word_offset_o),
  .row_last_o    (row_last_o),
  .glyph_last_o  (glyph_last_o)
);

`default_nettype wire

// ===== test/glyph_row_pixel_expander_tb.sv =====
// Self-checking testbench for the glyph row pixel expander.
`timescale 1ns / 1ps

module glyph_row_pixel_expander_tb;
  import grpe_pkg::*;

  localparam int HALF_PERIOD   = 1;       // 2 ns clock
  localparam int RESET_CYCLES  = 12;
  localparam int GLYPH_ROWS    = GLYPH_ROWS_DEF;
  localparam int MAX_SCALE     = MAX_SCALE_DEF;
  localparam int NARROW_PIX    = 8;
  localparam int WIDE_PIX      = 16;
  localparam int RAND_PHASES   = 8;
  localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
  localparam int SETTLE_CYCLES = 4;       // idle margin before a register write
  localparam int END_WAIT      = 20;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int MAX_REPORTS   = 40;

  // Expected-word store plus a private copy of the block's registers and row counter.
  class glyph_word_board;
    word_t              pending_words[$];
    logic [SCALE_W-1:0] scale_r;
    logic [COLOR_W-1:0] color_r;
    logic [PITCH_W-1:0] pitch_r;
    logic               wide_r;
    int unsigned        row_r;
    int                 errors;

    function new();
      scale_r = SCALE_RST;
      color_r = COLOR_RST;
      pitch_r = PITCH_RST;
      wide_r  = 1'b0;
      row_r   = 0;
      errors  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SCALE: scale_r = data[SCALE_W-1:0];
        CFG_COLOR: color_r = data[COLOR_W-1:0];
        CFG_PITCH: pitch_r = data[PITCH_W-1:0];
        CFG_WIDE:  wide_r  = data[0];
        default: ;
      endcase
    endfunction

    // Expand one glyph row into its scaled pixel words.
    function void note_row(logic [BYTE_W-1:0] left, logic [BYTE_W-1:0] right);
      int unsigned       sc;
      int unsigned       per_line;
      int unsigned       total;
      int unsigned       n;
      int unsigned       src;
      logic [ROW_BITS_W-1:0] row_bits;
      logic [31:0]       off;
      word_t             w_exp;
      sc = scale_r;
      if (sc == 0) sc = 1;
      if (sc > MAX_SCALE) sc = MAX_SCALE;
      row_bits = {left, wide_r ? right : {BYTE_W{1'b0}}};
      per_line = ((wide_r ? WIDE_PIX : NARROW_PIX) * sc) / PIX_PER_WORD;
      total    = per_line * sc;
      n        = 0;
      for (int unsigned ln = 0; ln < sc; ln++) begin
        for (int unsigned wi = 0; wi < per_line; wi++) begin
          w_exp.pixel_word = '0;
          for (int unsigned p = 0; p < PIX_PER_WORD; p++) begin
            src = (wi * PIX_PER_WORD + p) / sc;
            if (row_bits[ROW_BITS_W-1-src])
              w_exp.pixel_word[PIX_W*p +: PIX_W] = color_r;
          end
          // offset wraps to 16 bits for big pitches
          off = (sc * row_r + ln) * pitch_r + wi;
          w_exp.word_offset = off[OFFSET_W-1:0];
          n++;
          w_exp.row_last   = (n == total);
          w_exp.glyph_last = (n == total) && (row_r == GLYPH_ROWS - 1);
          pending_words.push_back(w_exp);
        end
      end
      row_r = (row_r >= GLYPH_ROWS - 1) ? 0 : row_r + 1;
    endfunction

    task check_word(word_t got);
      word_t want;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word %h at offset %0d", got.pixel_word,
                         got.word_offset));
        return;
      end
      want = pending_words.pop_front();
      if (got.pixel_word !== want.pixel_word)
        report($sformatf("pixel_word %h, want %h", got.pixel_word, want.pixel_word));
      if (got.word_offset !== want.word_offset)
        report($sformatf("word_offset %0d, want %0d", got.word_offset,
                         want.word_offset));
      if (got.row_last !== want.row_last)
        report($sformatf("row_last %b, want %b", got.row_last, want.row_last));
      if (got.glyph_last !== want.glyph_last)
        report($sformatf("glyph_last %b, want %b", got.glyph_last, want.glyph_last));
    endtask

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("mismatch @%0t: %s", $realtime, msg);
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [BYTE_W-1:0]     left_bits;
  logic [BYTE_W-1:0]     right_bits;
  logic                  out_valid;
  logic                  out_stall;
  logic [WORD_W-1:0]     pixel_word;
  logic [OFFSET_W-1:0]   word_offset;
  logic                  row_last;
  logic                  glyph_last;

  glyph_word_board board;
  int              words_seen;
  bit              hold_go;     // raised by the stimulus, served once by the receiver

  glyph_row_pixel_expander u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .left_bits_i   (left_bits),
    .right_bits_i  (right_bits),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .pixel_word_o  (pixel_word),
    .word_offset_o (word_offset),
    .row_last_o    (row_last),
    .glyph_last_o  (glyph_last)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Offer one row request and hold it until the block takes it. The expectation
  // is logged at the accepting edge itself, so a later drain cannot miss it.
  task automatic send_row(input logic [BYTE_W-1:0] l, input logic [BYTE_W-1:0] r);
    in_valid   <= 1'b1;
    left_bits  <= l;
    right_bits <= r;
    do @(posedge clk); while (in_stall);
    board.note_row(l, r);
  endtask

  // Sender gap; valid drops only when a real gap follows, so back-to-back
  // requests never see valid lowered and raised in one step.
  task automatic pause(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Every row yields at least two words, so an empty store plus a short
  // margin means the word generator is idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    board.set_reg(idx, data);
  endtask

  // Full register update between phases, plus a write to an unused index that
  // the block has to ignore.
  task automatic set_config(input logic [CFG_DATA_W-1:0] sc,
                            input logic [CFG_DATA_W-1:0] color,
                            input logic [CFG_DATA_W-1:0] pitch,
                            input logic [CFG_DATA_W-1:0] wide);
    drain();
    write_reg(CFG_SCALE, sc);
    write_reg(CFG_COLOR, color);
    write_reg(CFG_PITCH, pitch);
    write_reg(CFG_WIDE, wide);
    write_reg(CFG_IDX_W'($urandom_range(CFG_WIDE + 1, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Font bytes lean toward blank and solid rows.
  function automatic logic [BYTE_W-1:0] font_byte();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_color();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // Pitch covers zero, the 11-bit maximum (upper data bits set) and random.
  function automatic logic [CFG_DATA_W-1:0] pick_pitch();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // Word monitor: compare every accepted pixel word against the oldest prediction.
  always @(posedge clk) begin : word_monitor
    word_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.pixel_word  = pixel_word;
      got.word_offset = word_offset;
      got.row_last    = row_last;
      got.glyph_last  = glyph_last;
      board.check_word(got);
      words_seen++;
    end
  end

  // Receiver: stretches of free flow, random stalls, a fixed stall pattern and
  // heavy stalling, plus one long hold-off that backs the block up into its
  // input while the sender keeps offering rows.
  initial begin : receiver
    int  mode;
    int  span;
    bit  held;
    out_stall = 1'b0;
    held      = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      for (int k = 0; k < span; k++) begin
        @(posedge clk);
        if (hold_go && !held) begin
          held = 1'b1;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 99) < 30);
          2:       out_stall <= ((k % 4) == 3) || ((k % 7) == 0);
          default: out_stall <= ($urandom_range(0, 99) < 70);
        endcase
      end
    end
  end

  // Watchdog on a plain cycle count.
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int n_items;
    int burst;
    board      = new();
    words_seen = 0;
    hold_go    = 1'b0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    left_bits  = '0;
    right_bits = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: scale one, white, narrow; right byte must be ignored.
    send_row(8'h00, 8'hFF);
    send_row(8'hFF, 8'h00);
    pause(3);
    send_row(8'h80, 8'hFF);
    send_row(8'h01, 8'hAA);

    // Scale zero acts as one; zero pitch folds lines onto the same offsets.
    set_config(16'd0, 16'h8001, 16'd0, 16'd1);
    send_row(8'hFF, 8'h00);
    send_row(8'h00, 8'hFF);
    send_row(8'hA5, 8'h5A);

    // Scale above the maximum clamps to four; largest pitch wraps the offset.
    set_config(16'd7, 16'h0000, 16'hFFFF, 16'd1);
    send_row(8'h80, 8'h01);
    send_row(8'hFF, 8'hFF);

    // Scale three exercises the divide-by-three pixel mapping, narrow mode.
    set_config(16'd3, 16'h1234, 16'd1, 16'd0);
    send_row(8'hC3, 8'h55);
    send_row(8'h3C, 8'hAA);
    send_row(8'h92, 8'h00);

    // Pitch of 1024, full wide row at scale four.
    set_config(16'd4, 16'hFFFF, 16'd1024, 16'd1);
    send_row(8'h81, 8'h7E);
    send_row(8'h55, 8'hAA);

    // Scale two, wide; keeps the row counter rolling toward the glyph end.
    set_config(16'd2, 16'h7C1F, 16'd160, 16'd1);
    send_row(8'hF0, 8'h0F);
    send_row(8'h0F, 8'hF0);
    pause(2);
    send_row(8'h18, 8'h24);
    send_row(8'hE7, 8'h99);

    // Random phases: new settings each time, bursty requests with random content.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_config(($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                             : CFG_DATA_W'($urandom_range(0, 7)),
                 pick_color(), pick_pitch(),
                 ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                             : CFG_DATA_W'($urandom_range(0, 1)));
      if (ph == 1) hold_go = 1'b1;
      n_items = $urandom_range(40, 52);
      while (n_items > 0) begin
        burst = ($urandom_range(0, 9) == 0) ? 30 : $urandom_range(1, 12);
        while (burst > 0 && n_items > 0) begin
          send_row(font_byte(), font_byte());
          burst--;
          n_items--;
        end
        pause($urandom_range(0, 6));
      end
    end

    drain();
    repeat (END_WAIT) @(posedge clk);
    if (board.pending_words.size() != 0)
      board.report($sformatf("%0d predicted words never arrived",
                             board.pending_words.size()));
    if (board.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
